>>> rtl/ppiu_pkg.sv
// Shared types, constants and helper functions of the palette index unpacker.
package ppiu_pkg;

	localparam int WORD_BITS      = 64;
	localparam int SECTION_VALUES = 16 * 16 * 16;
	localparam int MAX_BPV        = 16;
	localparam int SIZE_W         = 17;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_DATA  = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;

	localparam logic [1:0] REG_BPV   = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;
	localparam logic [1:0] REG_PSIZE = 2'd2;

	typedef struct packed {
		logic        valid;
		logic [15:0] raw;
		logic [11:0] pos;
		logic        bad;
		logic        last;
	} issue_t;

	// clamp the configured width into 1..16
	function automatic logic [4:0] clamp_bpv(input logic [4:0] bpv);
		logic [4:0] r;
		r = bpv;
		if (bpv == 5'd0) r = 5'd1;
		else if (bpv > 5'(MAX_BPV)) r = 5'(MAX_BPV);
		return r;
	endfunction

	// indices held by one word at a clamped width
	function automatic logic [6:0] values_per_word(input logic [4:0] bpv);
		logic [6:0] n;
		unique case (bpv)
			5'd1:    n = 7'd64;
			5'd2:    n = 7'd32;
			5'd3:    n = 7'd21;
			5'd4:    n = 7'd16;
			5'd5:    n = 7'd12;
			5'd6:    n = 7'd10;
			5'd7:    n = 7'd9;
			5'd8:    n = 7'd8;
			5'd9:    n = 7'd7;
			5'd10:   n = 7'd6;
			5'd11:   n = 7'd5;
			5'd12:   n = 7'd5;
			5'd13:   n = 7'd4;
			5'd14:   n = 7'd4;
			5'd15:   n = 7'd4;
			5'd16:   n = 7'd4;
			default: n = 7'd64;
		endcase
		return n;
	endfunction

	function automatic logic [15:0] index_mask(input logic [4:0] bpv);
		logic [16:0] m;
		m = (17'd1 << bpv) - 17'd1;
		return m[15:0];
	endfunction

endpackage

>>> rtl/ppiu_unpack.sv
// Word shift register that peels one index per cycle while adv is high, and tracks the section.
module ppiu_unpack import ppiu_pkg::*; #(
	parameter int PALETTE_DEPTH = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [63:0]          data_word,
	input  logic [4:0]           cfg_bpv,
	input  logic [12:0]          value_count,
	input  logic [12:0]          cfg_psize,
	input  logic                 adv,
	output issue_t               issue
);

	logic [WORD_BITS-1:0] word_q;
	logic [6:0]           left_q;
	logic [12:0]          done_q;
	logic                 failed_q;
	logic                 busy_q;

	logic [4:0]        bpv;
	logic [12:0]       count;
	logic [SIZE_W-1:0] psize;
	logic [SIZE_W-1:0] psize_in;
	logic [15:0]       raw;
	logic              stop;
	logic              bad;
	logic              is_last;
	logic              accept;

	assign bpv      = clamp_bpv(cfg_bpv);
	assign count    = (value_count > 13'(SECTION_VALUES)) ? 13'(SECTION_VALUES) : value_count;
	assign psize_in = SIZE_W'(cfg_psize);
	assign psize    = (psize_in > SIZE_W'(PALETTE_DEPTH)) ? SIZE_W'(PALETTE_DEPTH) : psize_in;

	assign raw     = word_q[15:0] & index_mask(bpv);
	assign stop    = failed_q || (done_q >= count);
	assign bad     = SIZE_W'(raw) >= psize;
	assign is_last = bad || (left_q == 7'd1) || ((done_q + 13'd1) >= count);

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	always_comb begin
		issue.valid = busy_q && !stop;
		issue.raw   = raw;
		issue.pos   = done_q[11:0];
		issue.bad   = bad;
		issue.last  = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= '0;
			failed_q <= 1'b0;
			left_q   <= '0;
		end else if (accept) begin
			if (action == ACT_DATA) begin
				busy_q <= 1'b1;
				left_q <= values_per_word(bpv);
			end else if (action == ACT_START) begin
				done_q   <= '0;
				failed_q <= 1'b0;
			end
		end else if (busy_q && adv) begin
			if (stop) begin
				busy_q <= 1'b0;
			end else begin
				left_q <= left_q - 7'd1;
				if (bad) failed_q <= 1'b1;
				else done_q <= done_q + 13'd1;
				if (is_last) busy_q <= 1'b0;
			end
		end
	end

	// payload only: load on a data beat, shift one index out per issue
	always_ff @(posedge clk) begin
		if (accept && action == ACT_DATA) word_q <= data_word;
		else if (busy_q && adv && !stop) word_q <= word_q >> bpv;
	end

endmodule

>>> rtl/ppiu_palette.sv
// Palette memory with registered read and the result register.
module ppiu_palette import ppiu_pkg::*; #(
	parameter int PALETTE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [11:0] wr_slot,
	input  logic [15:0] wr_data,
	input  issue_t      issue,
	output logic        adv,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] global_id,
	output logic [15:0] raw_index,
	output logic [11:0] position,
	output logic        bad_index,
	output logic        last
);

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic [15:0] mem [PALETTE_DEPTH];
	logic [15:0] rdata_s1;
	logic        valid_s1;
	logic [15:0] raw_s1;
	logic [11:0] pos_s1;
	logic        bad_s1;
	logic        last_s1;

	assign adv = !valid_s1 || out_ready;

	// slots beyond the depth are dropped
	always_ff @(posedge clk) begin
		if (wr_en && (32'(wr_slot) < PALETTE_DEPTH)) mem[AW'(wr_slot)] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_s1 <= mem[AW'(issue.raw)];
			raw_s1   <= issue.raw;
			pos_s1   <= issue.pos;
			bad_s1   <= issue.bad;
			last_s1  <= issue.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (adv) valid_s1 <= issue.valid;
	end

	assign out_valid = valid_s1;
	assign global_id = bad_s1 ? 16'd0 : rdata_s1;
	assign raw_index = raw_s1;
	assign position  = pos_s1;
	assign bad_index = bad_s1;
	assign last      = last_s1;

endmodule

>>> rtl/packed_palette_index_unpacker.sv
// Flow: a data word is accepted into the word shift register, which peels one index
// per cycle while out_ready lets the result register advance; each index's palette
// read and result are registered together. No new beat is taken while a word is in
// progress; a word ends at its last index, at the count or at a bad index.
// Palette and start beats are taken without occupying the unpacker.
// Reset clears section state and control, loads register defaults; palette is not cleared.
module packed_palette_index_unpacker import ppiu_pkg::*; #(
	parameter int PALETTE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [11:0] palette_index,
	input  logic [15:0] palette_value,
	input  logic [63:0] data_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] global_id,
	output logic [15:0] raw_index,
	output logic [11:0] position,
	output logic        bad_index,
	output logic        last
);

	logic [4:0]  bpv_q;
	logic [12:0] count_q;
	logic [12:0] psize_q;
	logic [1:0]  reg_idx;
	logic        cfg_wr;
	logic        adv;
	logic        pal_wr;
	issue_t      issue;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpv_q   <= 5'd4;
			count_q <= 13'(SECTION_VALUES);
			psize_q <= 13'd1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BPV:   bpv_q   <= pwdata[4:0];
				REG_COUNT: count_q <= pwdata[12:0];
				REG_PSIZE: psize_q <= pwdata[12:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BPV:   prdata = {27'd0, bpv_q};
			REG_COUNT: prdata = {19'd0, count_q};
			REG_PSIZE: prdata = {19'd0, psize_q};
			default:   prdata = 32'd0;
		endcase
	end

	assign pal_wr = in_valid && in_ready && (action == ACT_LOAD);

	ppiu_unpack #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.data_word   (data_word),
		.cfg_bpv     (bpv_q),
		.value_count (count_q),
		.cfg_psize   (psize_q),
		.adv         (adv),
		.issue       (issue)
	);

	ppiu_palette #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_palette (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (pal_wr),
		.wr_slot   (palette_index),
		.wr_data   (palette_value),
		.issue     (issue),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.global_id (global_id),
		.raw_index (raw_index),
		.position  (position),
		.bad_index (bad_index),
		.last      (last)
	);

	// an error beat closes the word
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_index |-> last)
		else $error("error result without last");

	// an error beat carries no palette id
	a_bad_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_index |-> global_id == 16'd0)
		else $error("error result with non-zero id");

	// palette and start beats never occupy the unpacker
	a_ctrl_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action != ACT_DATA) |=> in_ready)
		else $error("unpacker busy after a non-data beat");

	// a result appears only after a data beat has been taken
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without a word in progress");

endmodule
